// ===== rtl/vector_alu_3d_assert.svh =====
`ifndef VECTOR_ALU_3D_ASSERT_SVH
`define VECTOR_ALU_3D_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define VA3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define VA3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/va3_pkg.sv =====
package va3_pkg;

  localparam int DIM = 3;

  typedef logic signed [31:0] word_t;

  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_SUB   = 5'd1,
    OP_NEG   = 5'd2,
    OP_SCALE = 5'd3,
    OP_SDIV  = 5'd4,
    OP_CMUL  = 5'd5,
    OP_CDIV  = 5'd6,
    OP_CROSS = 5'd7,
    OP_DOT   = 5'd8,
    OP_MAG   = 5'd9,
    OP_SUM   = 5'd10,
    OP_UNIT  = 5'd11,
    OP_PROJ  = 5'd12,
    OP_MIN   = 5'd13,
    OP_MAX   = 5'd14,
    OP_TAXI  = 5'd15,
    OP_EQ    = 5'd16,
    OP_NE    = 5'd17,
    OP_GT    = 5'd18,
    OP_LT    = 5'd19,
    OP_GE    = 5'd20,
    OP_LE    = 5'd21
  } op_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [4:0]            func;
    word_t [DIM-1:0]       a;
    word_t [DIM-1:0]       b;
    word_t                 s;
  } item_t;

  typedef struct packed {
    word_t [DIM-1:0]       r;
    word_t                 scal;
    logic [DIM-1:0]        mask;
    logic                  all_set;
    logic                  any_set;
    logic                  most_set;
    logic                  err;
  } res_t;

  typedef struct packed {
    logic [4:0]                func;
    res_t                      early;
    logic [DIM-1:0][63:0]      num_mag;
    logic [DIM-1:0]            num_neg;
    logic [DIM-1:0][31:0]      den_mag;
    logic [DIM-1:0]            den_neg;
  } prep_t;

  typedef struct packed {
    logic [4:0]                func;
    res_t                      early;
    logic [31:0]               root;
    logic [DIM-1:0][31:0]      den_mag;
    logic [DIM-1:0]            q_neg;
    logic [DIM-1:0]            den_zero;
    logic [DIM-1:0]            ovf;
  } dside_t;

  function automatic word_t sat_w(input logic signed [67:0] v);
    word_t res;
    if (v > 68'sd2147483647) begin
      res = WORD_MAX;
    end else if (v < -68'sd2147483648) begin
      res = WORD_MIN;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/va3_if.sv =====
interface va3_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         func;
  logic signed [31:0] a_x;
  logic signed [31:0] a_y;
  logic signed [31:0] a_z;
  logic signed [31:0] b_x;
  logic signed [31:0] b_y;
  logic signed [31:0] b_z;
  logic signed [31:0] scale_val;

  modport source (
    output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scale_val,
    input  ready
  );
  modport sink (
    input  valid, func, a_x, a_y, a_z, b_x, b_y, b_z, scale_val,
    output ready
  );
endinterface

interface va3_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] r_x;
  logic signed [31:0] r_y;
  logic signed [31:0] r_z;
  logic signed [31:0] scalar_out;
  logic [2:0]         cmp_mask;
  logic               all_set;
  logic               any_set;
  logic               most_set;
  logic               div_error;

  modport source (
    output valid, r_x, r_y, r_z, scalar_out, cmp_mask, all_set, any_set, most_set,
           div_error,
    input  ready
  );
  modport sink (
    input  valid, r_x, r_y, r_z, scalar_out, cmp_mask, all_set, any_set, most_set,
           div_error,
    output ready
  );
endinterface

// ===== rtl/va3_front.sv =====
module va3_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  va3_pkg::item_t    in_item,
  output logic              out_vld,
  output va3_pkg::prep_t    out_prep,
  output logic [63:0]       out_sq
);

  localparam int DIM = va3_pkg::DIM;

  // product stage
  logic                 vp_r;
  va3_pkg::item_t       itp_r;
  logic signed [63:0]   p_as_r [DIM];
  logic signed [63:0]   p_ab_r [DIM];
  logic signed [63:0]   p_aa_r [DIM];
  logic signed [63:0]   p_bb_r [DIM];
  logic signed [63:0]   p_c0_r [DIM];
  logic signed [63:0]   p_c1_r [DIM];

  // reduction stage
  logic                 vr_r;
  va3_pkg::item_t       itr_r;
  va3_pkg::res_t        early_r;
  va3_pkg::word_t       e_r;
  va3_pkg::word_t       d_r;
  logic [63:0]          sq_r;

  // operand stage
  logic                 vm_r;
  va3_pkg::prep_t       prep_r;
  logic [63:0]          sqm_r;

  va3_pkg::word_t       add_w [DIM];
  va3_pkg::word_t       sub_w [DIM];
  va3_pkg::word_t       neg_w [DIM];
  va3_pkg::word_t       scl_w [DIM];
  va3_pkg::word_t       cml_w [DIM];
  va3_pkg::word_t       crs_w [DIM];
  va3_pkg::word_t       min_w [DIM];
  va3_pkg::word_t       max_w [DIM];
  logic signed [33:0]   adf_w [DIM];
  logic [DIM-1:0]       eq_b;
  logic [DIM-1:0]       gt_b;
  logic [DIM-1:0]       lt_b;

  logic signed [65:0]   dot_ab;
  logic signed [65:0]   dot_bb;
  va3_pkg::word_t       e_nxt;
  va3_pkg::word_t       d_nxt;
  logic [63:0]          sq_nxt;
  va3_pkg::res_t        early_nxt;
  logic [DIM-1:0]       mask_c;

  va3_pkg::prep_t       prep_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vr_r <= 1'b0;
      vm_r <= 1'b0;
    end else if (en) begin
      vp_r <= in_vld;
      vr_r <= vp_r;
      vm_r <= vr_r;
    end
  end

  for (genvar g = 0; g < DIM; g++) begin : g_lane
    localparam int J = (g + 1) % DIM;
    localparam int K = (g + 2) % DIM;

    va3_pkg::word_t     ax;
    va3_pkg::word_t     bx;
    va3_pkg::word_t     ra;
    va3_pkg::word_t     rb;
    logic signed [65:0] cs;
    logic signed [33:0] df;
    logic signed [63:0] pe;
    logic signed [63:0] num;
    va3_pkg::word_t     den;

    always_ff @(posedge clk) begin
      if (en) begin
        p_as_r[g] <= in_item.a[g] * in_item.s;
        p_ab_r[g] <= in_item.a[g] * in_item.b[g];
        p_aa_r[g] <= in_item.a[g] * in_item.a[g];
        p_bb_r[g] <= in_item.b[g] * in_item.b[g];
        p_c0_r[g] <= in_item.a[J] * in_item.b[K];
        p_c1_r[g] <= in_item.a[K] * in_item.b[J];
      end
    end

    assign ax = itp_r.a[g];
    assign bx = itp_r.b[g];
    assign cs = 66'(p_c0_r[g]) - 66'(p_c1_r[g]);
    assign df = 34'(ax) - 34'(bx);

    assign add_w[g] = va3_pkg::sat_w(68'(ax) + 68'(bx));
    assign sub_w[g] = va3_pkg::sat_w(68'(ax) - 68'(bx));
    assign neg_w[g] = va3_pkg::sat_w(-68'(ax));
    assign scl_w[g] = va3_pkg::sat_w(68'(p_as_r[g] >>> FRAC_BITS));
    assign cml_w[g] = va3_pkg::sat_w(68'(p_ab_r[g] >>> FRAC_BITS));
    assign crs_w[g] = va3_pkg::sat_w(68'(cs >>> FRAC_BITS));
    assign min_w[g] = (ax < bx) ? ax : bx;
    assign max_w[g] = (ax > bx) ? ax : bx;
    assign adf_w[g] = df[33] ? -df : df;
    assign eq_b[g]  = (ax == bx);
    assign gt_b[g]  = (ax > bx);
    assign lt_b[g]  = (ax < bx);

    // divider operands for this lane
    assign ra  = itr_r.a[g];
    assign rb  = itr_r.b[g];
    assign pe  = rb * e_r;
    assign num = (itr_r.func == va3_pkg::OP_PROJ) ? pe : (64'(ra) <<< FRAC_BITS);

    always_comb begin
      case (va3_pkg::op_t'(itr_r.func))
        va3_pkg::OP_SDIV: den = itr_r.s;
        va3_pkg::OP_CDIV: den = rb;
        va3_pkg::OP_PROJ: den = d_r;
        default:          den = '0;
      endcase
    end

    assign prep_nxt.num_neg[g] = num[63];
    assign prep_nxt.num_mag[g] = num[63] ? (~num + 64'd1) : num;
    assign prep_nxt.den_neg[g] = den[31];
    assign prep_nxt.den_mag[g] = den[31] ? (~den + 32'd1) : den;
  end

  assign dot_ab = 66'(p_ab_r[0]) + 66'(p_ab_r[1]) + 66'(p_ab_r[2]);
  assign dot_bb = 66'(p_bb_r[0]) + 66'(p_bb_r[1]) + 66'(p_bb_r[2]);
  assign e_nxt  = va3_pkg::sat_w(68'(dot_ab >>> FRAC_BITS));
  assign d_nxt  = va3_pkg::sat_w(68'(dot_bb >>> FRAC_BITS));
  assign sq_nxt = p_aa_r[0] + p_aa_r[1] + p_aa_r[2];

  always_comb begin
    early_nxt = '0;
    mask_c    = '0;
    case (va3_pkg::op_t'(itp_r.func))
      va3_pkg::OP_ADD:   for (int i = 0; i < DIM; i++) early_nxt.r[i] = add_w[i];
      va3_pkg::OP_SUB:   for (int i = 0; i < DIM; i++) early_nxt.r[i] = sub_w[i];
      va3_pkg::OP_NEG:   for (int i = 0; i < DIM; i++) early_nxt.r[i] = neg_w[i];
      va3_pkg::OP_SCALE: for (int i = 0; i < DIM; i++) early_nxt.r[i] = scl_w[i];
      va3_pkg::OP_CMUL:  for (int i = 0; i < DIM; i++) early_nxt.r[i] = cml_w[i];
      va3_pkg::OP_CROSS: for (int i = 0; i < DIM; i++) early_nxt.r[i] = crs_w[i];
      va3_pkg::OP_MIN:   for (int i = 0; i < DIM; i++) early_nxt.r[i] = min_w[i];
      va3_pkg::OP_MAX:   for (int i = 0; i < DIM; i++) early_nxt.r[i] = max_w[i];
      va3_pkg::OP_DOT:   early_nxt.scal = e_nxt;
      va3_pkg::OP_SUM:
        early_nxt.scal = va3_pkg::sat_w(68'(itp_r.a[0]) + 68'(itp_r.a[1]) + 68'(itp_r.a[2]));
      va3_pkg::OP_TAXI:
        early_nxt.scal = va3_pkg::sat_w(68'(adf_w[0]) + 68'(adf_w[1]) + 68'(adf_w[2]));
      va3_pkg::OP_EQ:    mask_c = eq_b;
      va3_pkg::OP_NE:    mask_c = ~eq_b;
      va3_pkg::OP_GT:    mask_c = gt_b;
      va3_pkg::OP_LT:    mask_c = lt_b;
      va3_pkg::OP_GE:    mask_c = ~lt_b;
      va3_pkg::OP_LE:    mask_c = ~gt_b;
      default: ;
    endcase
    early_nxt.mask     = mask_c;
    early_nxt.all_set  = &mask_c;
    early_nxt.any_set  = |mask_c;
    early_nxt.most_set = (mask_c[0] & mask_c[1]) | (mask_c[0] & mask_c[2])
                       | (mask_c[1] & mask_c[2]);
  end

  assign prep_nxt.func  = itr_r.func;
  assign prep_nxt.early = early_r;

  always_ff @(posedge clk) begin
    if (en) begin
      itp_r   <= in_item;
      itr_r   <= itp_r;
      early_r <= early_nxt;
      e_r     <= e_nxt;
      d_r     <= d_nxt;
      sq_r    <= sq_nxt;
      prep_r  <= prep_nxt;
      sqm_r   <= sq_r;
    end
  end

  assign out_vld  = vm_r;
  assign out_prep = prep_r;
  assign out_sq   = sqm_r;

endmodule

// ===== rtl/va3_sqrt.sv =====
module va3_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  va3_pkg::prep_t    in_side,
  input  logic [63:0]       in_val,
  output logic              out_vld,
  output va3_pkg::prep_t    out_side,
  output logic [31:0]       out_root
);

  localparam int STEPS = 32;

  logic            vld_r  [STEPS];
  va3_pkg::prep_t  side_r [STEPS];
  logic [35:0]     rem_r  [STEPS];
  logic [31:0]     root_r [STEPS];
  logic [63:0]     val_r  [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic            src_vld;
    va3_pkg::prep_t  src_side;
    logic [35:0]     src_rem;
    logic [31:0]     src_root;
    logic [63:0]     src_val;
    logic [35:0]     cur;
    logic [35:0]     trial;

    if (g == 0) begin : g_head
      assign src_vld  = in_vld;
      assign src_side = in_side;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_val  = in_val;
    end else begin : g_link
      assign src_vld  = vld_r[g-1];
      assign src_side = side_r[g-1];
      assign src_rem  = rem_r[g-1];
      assign src_root = root_r[g-1];
      assign src_val  = val_r[g-1];
    end

    // one root bit per stage
    assign cur   = {src_rem[33:0], src_val[63:62]};
    assign trial = {2'b00, src_root, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g] <= src_side;
        val_r[g]  <= {src_val[61:0], 2'b00};
        if (cur >= trial) begin
          rem_r[g]  <= cur - trial;
          root_r[g] <= {src_root[30:0], 1'b1};
        end else begin
          rem_r[g]  <= cur;
          root_r[g] <= {src_root[30:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_side = side_r[STEPS-1];
  assign out_root = root_r[STEPS-1];

endmodule

// ===== rtl/va3_div.sv =====
module va3_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  va3_pkg::prep_t                  in_side,
  input  logic [31:0]                     in_root,
  output logic                            out_vld,
  output va3_pkg::dside_t                 out_side,
  output logic [va3_pkg::DIM-1:0][31:0]   out_quot
);

  localparam int DIM   = va3_pkg::DIM;
  localparam int STEPS = 32;

  // setup stage
  logic              sv_r;
  va3_pkg::dside_t   ds_r;
  logic [31:0]       rem0_r [DIM];
  logic [31:0]       low0_r [DIM];
  va3_pkg::dside_t   ds_nxt;
  logic              is_unit;

  // quotient stages
  logic              vld_r  [STEPS];
  va3_pkg::dside_t   side_r [STEPS];
  logic [31:0]       rem_r  [STEPS][DIM];
  logic [31:0]       low_r  [STEPS][DIM];
  logic [31:0]       quot_r [STEPS][DIM];

  assign is_unit = (in_side.func == va3_pkg::OP_UNIT);

  always_comb begin
    ds_nxt       = '0;
    ds_nxt.func  = in_side.func;
    ds_nxt.early = in_side.early;
    ds_nxt.root  = in_root;
    for (int l = 0; l < DIM; l++) begin
      ds_nxt.den_mag[l]  = is_unit ? in_root : in_side.den_mag[l];
      ds_nxt.q_neg[l]    = in_side.num_neg[l] ^ (in_side.den_neg[l] & ~is_unit);
      ds_nxt.den_zero[l] = (ds_nxt.den_mag[l] == '0);
      ds_nxt.ovf[l]      = (in_side.num_mag[l][63:32] >= ds_nxt.den_mag[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (en) begin
      sv_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds_r <= ds_nxt;
      for (int l = 0; l < DIM; l++) begin
        rem0_r[l] <= in_side.num_mag[l][63:32];
        low0_r[l] <= in_side.num_mag[l][31:0];
      end
    end
  end

  for (genvar g = 0; g < STEPS; g++) begin : g_step
    logic              src_vld;
    va3_pkg::dside_t   src_side;

    if (g == 0) begin : g_head
      assign src_vld  = sv_r;
      assign src_side = ds_r;
    end else begin : g_link
      assign src_vld  = vld_r[g-1];
      assign src_side = side_r[g-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_r[g] <= src_side;
      end
    end

    for (genvar l = 0; l < DIM; l++) begin : g_lane
      logic [31:0] src_rem;
      logic [31:0] src_low;
      logic [31:0] src_quot;
      logic [32:0] cur;
      logic [32:0] diff;

      if (g == 0) begin : g_head
        assign src_rem  = rem0_r[l];
        assign src_low  = low0_r[l];
        assign src_quot = '0;
      end else begin : g_link
        assign src_rem  = rem_r[g-1][l];
        assign src_low  = low_r[g-1][l];
        assign src_quot = quot_r[g-1][l];
      end

      // restoring step, one quotient bit
      assign cur  = {src_rem, src_low[31]};
      assign diff = cur - {1'b0, src_side.den_mag[l]};

      always_ff @(posedge clk) begin
        if (en) begin
          low_r[g][l] <= {src_low[30:0], 1'b0};
          if (!diff[32]) begin
            rem_r[g][l]  <= diff[31:0];
            quot_r[g][l] <= {src_quot[30:0], 1'b1};
          end else begin
            rem_r[g][l]  <= cur[31:0];
            quot_r[g][l] <= {src_quot[30:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_side = side_r[STEPS-1];

  for (genvar l = 0; l < DIM; l++) begin : g_out
    assign out_quot[l] = quot_r[STEPS-1][l];
  end

endmodule

// ===== rtl/vector_alu_3d.sv =====
// channel   dir   handshake      payload
// in_chan   in    valid/ready    func, a_x..a_z, b_x..b_z, scale_val
// out_chan  out   valid/ready    r_x..r_z, scalar_out, cmp_mask, flags, div_error
//
// one transaction accepted per cycle while the output is not stalled
// the path runs through the front end, the 32-stage square root, the 33-stage divider and an output register
// reset clears the stage valid bits only, no clearing pass
// a stalled output freezes the whole pipeline, in_chan.ready follows it
module vector_alu_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  va3_in_if.sink        in_chan,
  va3_out_if.source     out_chan
);

  localparam int DIM = va3_pkg::DIM;

  logic                            en;
  va3_pkg::item_t                  item;

  logic                            fr_vld;
  va3_pkg::prep_t                  fr_prep;
  logic [63:0]                     fr_sq;

  logic                            sq_vld;
  va3_pkg::prep_t                  sq_side;
  logic [31:0]                     sq_root;

  logic                            dv_vld;
  va3_pkg::dside_t                 dv_side;
  logic [DIM-1:0][31:0]            dv_quot;

  logic                            out_valid_r;
  va3_pkg::res_t                   res_r;
  va3_pkg::res_t                   res_nxt;

  function automatic va3_pkg::word_t quot_sat(input logic [31:0] q, input logic neg,
                                              input logic ovf);
    va3_pkg::word_t res;
    if (!neg) begin
      res = (ovf || q[31]) ? va3_pkg::WORD_MAX : q;
    end else if (ovf || q > 32'h8000_0000) begin
      res = va3_pkg::WORD_MIN;
    end else begin
      res = ~q + 32'd1;
    end
    return res;
  endfunction

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  assign item.func = in_chan.func;
  assign item.a[0] = in_chan.a_x;
  assign item.a[1] = in_chan.a_y;
  assign item.a[2] = in_chan.a_z;
  assign item.b[0] = in_chan.b_x;
  assign item.b[1] = in_chan.b_y;
  assign item.b[2] = in_chan.b_z;
  assign item.s    = in_chan.scale_val;

  va3_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_chan.valid),
    .in_item  (item),
    .out_vld  (fr_vld),
    .out_prep (fr_prep),
    .out_sq   (fr_sq)
  );

  va3_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (fr_vld),
    .in_side  (fr_prep),
    .in_val   (fr_sq),
    .out_vld  (sq_vld),
    .out_side (sq_side),
    .out_root (sq_root)
  );

  va3_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (sq_vld),
    .in_side  (sq_side),
    .in_root  (sq_root),
    .out_vld  (dv_vld),
    .out_side (dv_side),
    .out_quot (dv_quot)
  );

  always_comb begin
    res_nxt = dv_side.early;
    case (va3_pkg::op_t'(dv_side.func))
      va3_pkg::OP_MAG: begin
        res_nxt.scal = dv_side.root[31] ? va3_pkg::WORD_MAX : dv_side.root;
      end
      va3_pkg::OP_SDIV, va3_pkg::OP_CDIV, va3_pkg::OP_UNIT, va3_pkg::OP_PROJ: begin
        for (int l = 0; l < DIM; l++) begin
          res_nxt.r[l] = dv_side.den_zero[l] ? '0
                       : quot_sat(dv_quot[l], dv_side.q_neg[l], dv_side.ovf[l]);
        end
        res_nxt.err = |dv_side.den_zero;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.r_x        = res_r.r[0];
  assign out_chan.r_y        = res_r.r[1];
  assign out_chan.r_z        = res_r.r[2];
  assign out_chan.scalar_out = res_r.scal;
  assign out_chan.cmp_mask   = res_r.mask;
  assign out_chan.all_set    = res_r.all_set;
  assign out_chan.any_set    = res_r.any_set;
  assign out_chan.most_set   = res_r.most_set;
  assign out_chan.div_error  = res_r.err;

endmodule

// ===== rtl/va3_checker.sv =====
`include "vector_alu_3d_assert.svh"

module va3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_r_x,
  input logic        out_all_set,
  input logic        out_any_set,
  input logic        out_most_set
);

  `VA3_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `VA3_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_r_x), "payload moved while stalled")
  `VA3_ASSERT_NOW(a_ready_follow, out_ready, in_ready, "input blocked with output drained")
  `VA3_ASSERT_NOW(a_flags, out_valid && out_all_set, out_most_set && out_any_set, "flags disagree")

endmodule

bind vector_alu_3d va3_checker u_va3_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .out_r_x      (out_chan.r_x),
  .out_all_set  (out_chan.all_set),
  .out_any_set  (out_chan.any_set),
  .out_most_set (out_chan.most_set)
);

// ===== test/va3_checker.sv =====
`timescale 1ns / 100ps

module va3_scoreboard #(
  parameter int FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  rst_n,
  va3_in_if     in_mon,
  va3_out_if    out_mon,
  output int    errors,
  output int    pending
);

  typedef logic signed [127:0] wide_t;

  va3_pkg::res_t expected_q[$];

  function automatic va3_pkg::word_t clamp32(input wide_t v);
    if (v > wide_t'(va3_pkg::WORD_MAX)) return va3_pkg::WORD_MAX;
    if (v < wide_t'(va3_pkg::WORD_MIN)) return va3_pkg::WORD_MIN;
    return va3_pkg::word_t'(v[31:0]);
  endfunction

  function automatic wide_t root_floor(input wide_t v);
    wide_t rem, acc, pw;
    rem = v;
    acc = 0;
    pw = wide_t'(1) <<< 64;
    while (pw > rem) pw = pw >>> 2;
    while (pw != 0) begin
      if (rem >= acc + pw) begin
        rem = rem - (acc + pw);
        acc = (acc >>> 1) + pw;
      end else begin
        acc = acc >>> 1;
      end
      pw = pw >>> 2;
    end
    return acc;
  endfunction

  function automatic wide_t dot_clamped(input wide_t p[3], input wide_t q[3]);
    return wide_t'(clamp32((p[0] * q[0] + p[1] * q[1] + p[2] * q[2]) >>> FRAC_BITS));
  endfunction

  function automatic va3_pkg::res_t compute_alu(input logic [4:0] func, input wide_t a[3],
                                                input wide_t b[3], input wide_t s);
    va3_pkg::res_t res;
    wide_t r[3];
    wide_t scal, sq, e, d;
    logic cmpop, c;
    int cnt;
    res = '0;
    scal = 0;
    cmpop = 1'b0;
    cnt = 0;
    for (int i = 0; i < 3; i++) r[i] = 0;
    case (func)
      va3_pkg::OP_ADD: for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
      va3_pkg::OP_SUB: for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      va3_pkg::OP_NEG: for (int i = 0; i < 3; i++) r[i] = -a[i];
      va3_pkg::OP_SCALE: for (int i = 0; i < 3; i++) r[i] = (a[i] * s) >>> FRAC_BITS;
      va3_pkg::OP_SDIV: begin
        if (s == 0) res.err = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = (a[i] <<< FRAC_BITS) / s;
      end
      va3_pkg::OP_CMUL: for (int i = 0; i < 3; i++) r[i] = (a[i] * b[i]) >>> FRAC_BITS;
      va3_pkg::OP_CDIV: begin
        for (int i = 0; i < 3; i++) begin
          if (b[i] == 0) res.err = 1'b1;
          else r[i] = (a[i] <<< FRAC_BITS) / b[i];
        end
      end
      va3_pkg::OP_CROSS: begin
        for (int i = 0; i < 3; i++)
          r[i] = (a[(i + 1) % 3] * b[(i + 2) % 3] - a[(i + 2) % 3] * b[(i + 1) % 3])
                 >>> FRAC_BITS;
      end
      va3_pkg::OP_DOT: scal = dot_clamped(a, b);
      va3_pkg::OP_MAG, va3_pkg::OP_UNIT: begin
        sq = root_floor(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
        if (func == va3_pkg::OP_MAG) scal = sq;
        else if (sq == 0) res.err = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = (a[i] <<< FRAC_BITS) / sq;
      end
      va3_pkg::OP_SUM: scal = a[0] + a[1] + a[2];
      va3_pkg::OP_PROJ: begin
        e = dot_clamped(a, b);
        d = dot_clamped(b, b);
        if (d == 0) res.err = 1'b1;
        else for (int i = 0; i < 3; i++) r[i] = (b[i] * e) / d;
      end
      va3_pkg::OP_MIN: for (int i = 0; i < 3; i++) r[i] = (a[i] < b[i]) ? a[i] : b[i];
      va3_pkg::OP_MAX: for (int i = 0; i < 3; i++) r[i] = (a[i] > b[i]) ? a[i] : b[i];
      va3_pkg::OP_TAXI:
        for (int i = 0; i < 3; i++) scal += (a[i] > b[i]) ? a[i] - b[i] : b[i] - a[i];
      va3_pkg::OP_EQ, va3_pkg::OP_NE, va3_pkg::OP_GT, va3_pkg::OP_LT, va3_pkg::OP_GE,
      va3_pkg::OP_LE: begin
        cmpop = 1'b1;
        for (int i = 0; i < 3; i++) begin
          case (func)
            va3_pkg::OP_EQ: c = a[i] == b[i];
            va3_pkg::OP_NE: c = a[i] != b[i];
            va3_pkg::OP_GT: c = a[i] > b[i];
            va3_pkg::OP_LT: c = a[i] < b[i];
            va3_pkg::OP_GE: c = a[i] >= b[i];
            default: c = a[i] <= b[i];
          endcase
          if (c) begin
            res.mask[i] = 1'b1;
            cnt++;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < 3; i++) res.r[i] = clamp32(r[i]);
    res.scal = clamp32(scal);
    res.all_set = cmpop && (res.mask == 3'b111);
    res.any_set = res.mask != 0;
    res.most_set = cnt >= 2;
    return res;
  endfunction

  task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
    errors++;
  endtask

  initial begin
    errors = 0;
  end

  assign pending = expected_q.size();

  always @(posedge clk) begin
    wide_t av[3], bv[3];
    va3_pkg::res_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        av[0] = in_mon.a_x; av[1] = in_mon.a_y; av[2] = in_mon.a_z;
        bv[0] = in_mon.b_x; bv[1] = in_mon.b_y; bv[2] = in_mon.b_z;
        expected_q.push_back(compute_alu(in_mon.func, av, bv, wide_t'(in_mon.scale_val)));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report("out_valid", 32'd1, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.r_x !== want.r[0]) report("r_x", out_mon.r_x, want.r[0]);
          if (out_mon.r_y !== want.r[1]) report("r_y", out_mon.r_y, want.r[1]);
          if (out_mon.r_z !== want.r[2]) report("r_z", out_mon.r_z, want.r[2]);
          if (out_mon.scalar_out !== want.scal)
            report("scalar_out", out_mon.scalar_out, want.scal);
          if (out_mon.cmp_mask !== want.mask) report("cmp_mask", out_mon.cmp_mask, want.mask);
          if (out_mon.all_set !== want.all_set) report("all_set", out_mon.all_set, want.all_set);
          if (out_mon.any_set !== want.any_set) report("any_set", out_mon.any_set, want.any_set);
          if (out_mon.most_set !== want.most_set)
            report("most_set", out_mon.most_set, want.most_set);
          if (out_mon.div_error !== want.err) report("div_error", out_mon.div_error, want.err);
        end
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 1800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 100;

  logic clk;
  logic rst_n;
  int errors;
  int pending;
  int cycles;
  int burst_left;
  bit holdoff_req;
  int ready_mode;

  va3_in_if in_chan ();
  va3_out_if out_chan ();

  vector_alu_3d dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  va3_scoreboard monitor (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_chan),
    .out_mon (out_chan),
    .errors  (errors),
    .pending (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: stall pattern plus one long hold-off
  initial begin
    int hold;
    out_chan.ready = 1'b0;
    ready_mode = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_chan.ready <= 1'b0;
        hold = 0;
        while (hold < 400) begin
          @(negedge clk);
          hold++;
        end
      end
      if ($urandom_range(0, 63) == 0) ready_mode = $urandom_range(0, 3);
      case (ready_mode)
        0: out_chan.ready <= 1'b1;
        1: out_chan.ready <= ($urandom_range(0, 3) != 0);
        2: out_chan.ready <= $urandom_range(0, 1);
        default: out_chan.ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  task automatic send(input logic [4:0] f, input va3_pkg::word_t ax, input va3_pkg::word_t ay,
                      input va3_pkg::word_t az, input va3_pkg::word_t bx,
                      input va3_pkg::word_t by, input va3_pkg::word_t bz,
                      input va3_pkg::word_t sv);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.func <= f;
    in_chan.a_x <= ax; in_chan.a_y <= ay; in_chan.a_z <= az;
    in_chan.b_x <= bx; in_chan.b_y <= by; in_chan.b_z <= bz;
    in_chan.scale_val <= sv;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  function automatic va3_pkg::word_t pick_word();
    case ($urandom_range(0, 7))
      0: return va3_pkg::WORD_MAX;
      1: return va3_pkg::WORD_MIN;
      2: return '0;
      3: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      4: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
      5: return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    va3_pkg::word_t v[7];
    logic [4:0] f;
    cycles = 0;
    burst_left = 0;
    holdoff_req = 0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.func = '0;
    in_chan.a_x = '0; in_chan.a_y = '0; in_chan.a_z = '0;
    in_chan.b_x = '0; in_chan.b_y = '0; in_chan.b_z = '0;
    in_chan.scale_val = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: every op at the extremes, zero divisors, reserved codes
    for (int op = 0; op < 22; op++)
      send(op[4:0], va3_pkg::WORD_MAX, va3_pkg::WORD_MIN, 32'sh0001_8000, va3_pkg::WORD_MIN,
           va3_pkg::WORD_MAX, -32'sh0002_0000, va3_pkg::WORD_MIN);
    send(va3_pkg::OP_NEG, va3_pkg::WORD_MIN, va3_pkg::WORD_MIN, va3_pkg::WORD_MAX,
         '0, '0, '0, '0);
    send(va3_pkg::OP_SDIV, 32'sh0001_0000, -1, 5, '0, '0, '0, '0);
    send(va3_pkg::OP_CDIV, 32'sh0003_0000, 7, -9, '0, 32'sh0002_0000, '0, '0);
    send(va3_pkg::OP_UNIT, '0, '0, '0, 1, 2, 3, '0);
    send(va3_pkg::OP_PROJ, 32'sh0001_0000, 2, 3, 1, '0, -1, '0);
    send(va3_pkg::OP_MAG, va3_pkg::WORD_MIN, va3_pkg::WORD_MIN, va3_pkg::WORD_MIN,
         '0, '0, '0, '0);
    send(5'd22, va3_pkg::WORD_MAX, va3_pkg::WORD_MAX, va3_pkg::WORD_MAX, va3_pkg::WORD_MAX,
         va3_pkg::WORD_MAX, va3_pkg::WORD_MAX, va3_pkg::WORD_MAX);
    send(5'd31, -1, -1, -1, -1, -1, -1, -1);
    send(va3_pkg::OP_EQ, 5, 6, 7, 5, 6, 7, '0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 600) holdoff_req = 1'b1;
      f = ($urandom_range(0, 15) == 0) ? 5'($urandom) : 5'($urandom_range(0, 21));
      for (int k = 0; k < 7; k++) v[k] = pick_word();
      if (f >= va3_pkg::OP_EQ && f <= va3_pkg::OP_LE && $urandom_range(0, 1)) begin
        v[3] = $urandom_range(0, 1) ? v[0] : v[3];
        v[4] = $urandom_range(0, 1) ? v[1] : v[4];
        v[5] = $urandom_range(0, 1) ? v[2] : v[5];
      end
      send(f, v[0], v[1], v[2], v[3], v[4], v[5], v[6]);
    end
    in_chan.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/va3_pkg.sv
rtl/va3_if.sv
rtl/va3_front.sv
rtl/va3_sqrt.sv
rtl/va3_div.sv
rtl/vector_alu_3d.sv
rtl/va3_checker.sv
test/va3_checker.sv
test/testbench.sv
